>>> rtl/hand_follow_drive_controller_defines.svh
// Assertion macros for the hand follow drive controller.
`ifndef HAND_FOLLOW_DRIVE_CONTROLLER_DEFINES_SVH
`define HAND_FOLLOW_DRIVE_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define HFDC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define HFDC_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define HFDC_ASSERT(lbl, prop, msg)
`define HFDC_NEVER(lbl, expr, msg)
`endif
`endif

>>> rtl/hfdc_pkg.sv
// Shared types, opcodes and constants of the hand follow drive controller.
package hfdc_pkg;

	localparam int DIV_BITS = 23;

	localparam logic [2:0] REG_TARGET_DISTANCE  = 3'd0;
	localparam logic [2:0] REG_TARGET_ANGLE     = 3'd1;
	localparam logic [2:0] REG_DISTANCE_GAIN    = 3'd2;
	localparam logic [2:0] REG_TURN_GAIN        = 3'd3;
	localparam logic [2:0] REG_MAX_SPEED        = 3'd4;
	localparam logic [2:0] REG_MAX_TURN_SPEED   = 3'd5;
	localparam logic [2:0] REG_HEIGHT_THRESHOLD = 3'd6;
	localparam logic [2:0] REG_ANGLE_SPAN       = 3'd7;

	localparam logic [4:0] OP_NOP   = 5'd0;
	localparam logic [4:0] OP_LOAD  = 5'd1;
	localparam logic [4:0] OP_ROT   = 5'd2;
	localparam logic [4:0] OP_MUL_R = 5'd3;
	localparam logic [4:0] OP_ERR   = 5'd4;
	localparam logic [4:0] OP_MUL_V = 5'd5;
	localparam logic [4:0] OP_CLP_V = 5'd6;
	localparam logic [4:0] OP_MUL_W = 5'd7;
	localparam logic [4:0] OP_CLP_W = 5'd8;
	localparam logic [4:0] OP_MUL_S = 5'd9;
	localparam logic [4:0] OP_DIV_I = 5'd10;
	localparam logic [4:0] OP_DIV   = 5'd11;
	localparam logic [4:0] OP_FIN   = 5'd12;
	localparam logic [4:0] OP_MUL_OV = 5'd13;
	localparam logic [4:0] OP_OUT_V = 5'd14;
	localparam logic [4:0] OP_MUL_OW = 5'd15;
	localparam logic [4:0] OP_OUT_W = 5'd16;
	localparam logic [4:0] OP_PUSH  = 5'd17;

	localparam logic signed [25:0] DEG180   = 26'sd11796480;
	localparam logic signed [17:0] INV_GAIN = 18'sd39797;

	typedef struct packed {
		logic [4:0] op;
		logic [4:0] idx;
	} cmd_t;

	typedef struct packed {
		logic [15:0]        target_distance;
		logic signed [15:0] target_angle;
		logic [15:0]        distance_gain;
		logic [15:0]        turn_gain;
		logic [14:0]        max_speed;
		logic [14:0]        max_turn_speed;
		logic signed [15:0] height_threshold;
		logic [14:0]        angle_error_span;
	} cfg_t;

	// atan(2^-i) in 2^-16 degree
	function automatic logic [21:0] atan_lut(input logic [4:0] i);
		logic [21:0] v;
		case (i)
			5'd0: v = 22'd2949120;
			5'd1: v = 22'd1740967;
			5'd2: v = 22'd919879;
			5'd3: v = 22'd466945;
			5'd4: v = 22'd234379;
			5'd5: v = 22'd117304;
			5'd6: v = 22'd58666;
			5'd7: v = 22'd29335;
			5'd8: v = 22'd14668;
			5'd9: v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/hfdc_datapath.sv
// Datapath: CORDIC, shared multiplier, divider, state and result registers.
module hfdc_datapath import hfdc_pkg::*; #(
	parameter int COUNT_MAX     = 64,
	parameter int COUNT_DROP    = 2,
	parameter int INERTIA_RISE  = 1024,
	parameter int INERTIA_FALL  = 2048,
	parameter int REVERSE_SHIFT = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  cfg_t               cfg,
	input  logic signed [15:0] hand_x,
	input  logic signed [15:0] hand_y,
	input  logic signed [15:0] hand_z,
	output logic signed [15:0] forward_speed,
	output logic signed [15:0] turn_rate,
	output logic               follow_active
);

	logic signed [27:0] x_q, y_q;
	logic signed [25:0] acc_q;
	logic               zero_q;
	logic [6:0]         hc_q;
	logic [15:0]        inertia_q;
	logic signed [45:0] p_q;
	logic signed [17:0] r_err_q;
	logic signed [16:0] s_err_q;
	logic signed [23:0] vq_q, wq_q;
	logic [14:0]        rem_q;
	logic [DIV_BITS-1:0] dv_q;
	logic signed [15:0] v_q, w_q;

	logic signed [27:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [27:0] hx_s, hy_s, dx, dy;
	logic signed [25:0] at;
	logic signed [45:0] rsum, vlim, wlim;
	logic [16:0]        r_val;
	logic signed [25:0] ab, bs;
	logic signed [15:0] bearing;
	logic [14:0]        span_e, e_abs, span_d;
	logic [16:0]        s_abs;
	logic [23:0]        av, aw;
	logic [15:0]        dt;
	logic               ge;
	logic [7:0]         hc_up;
	logic [6:0]         hc_n;
	logic [16:0]        in_up, in_n;
	logic               moving;
	logic [38:0]        pm;
	logic [15:0]        m_v, m_w;

	assign hx_s = 28'(hand_x) <<< 8;
	assign hy_s = 28'(hand_y) <<< 8;
	assign dx = y_q >>> cmd.idx;
	assign dy = x_q >>> cmd.idx;
	assign at = $signed({4'd0, atan_lut(cmd.idx)});

	assign rsum  = p_q + 46'sd8388608;
	assign r_val = rsum[40:24];
	assign ab    = acc_q + 26'sd256;
	assign bs    = ab >>> 9;
	always_comb begin
		if (bs > 26'sd23040)
			bearing = 16'sd23040;
		else if (bs < -26'sd23040)
			bearing = -16'sd23040;
		else
			bearing = bs[15:0];
	end

	assign vlim = $signed({23'd0, cfg.max_speed, 8'd0});
	assign wlim = $signed({23'd0, cfg.max_turn_speed, 8'd0});

	assign span_e = (cfg.angle_error_span == 15'd0) ? 15'd1 : cfg.angle_error_span;
	assign s_abs  = s_err_q[16] ? 17'(-s_err_q) : 17'(s_err_q);
	assign e_abs  = (s_abs > {2'd0, span_e}) ? span_e : s_abs[14:0];
	assign span_d = span_e - e_abs;

	assign av = vq_q[23] ? 24'(-vq_q) : 24'(vq_q);
	assign aw = wq_q[23] ? 24'(-wq_q) : 24'(wq_q);

	assign dt = {rem_q, dv_q[DIV_BITS-1]};
	assign ge = dt >= {1'b0, span_e};

	assign hc_up = {1'b0, hc_q} + 8'd1;
	always_comb begin
		if (hand_z > cfg.height_threshold)
			hc_n = (hc_up > 8'(COUNT_MAX)) ? 7'(COUNT_MAX) : hc_up[6:0];
		else
			hc_n = (hc_q < 7'(COUNT_DROP)) ? 7'd0 : hc_q - 7'(COUNT_DROP);
	end

	// dv_q holds the unsigned quotient at FIN; vq_q still carries the sign
	assign moving = ({1'b0, dv_q} > {cfg.max_speed, 4'd0}) ||
		(aw > {5'd0, cfg.max_turn_speed, 4'd0});
	assign in_up = {1'b0, inertia_q} + 17'(INERTIA_RISE);
	always_comb begin
		if (hc_q == 7'd0)
			in_n = 17'd0;
		else if (moving)
			in_n = (in_up > 17'd32768) ? 17'd32768 : in_up;
		else
			in_n = ({1'b0, inertia_q} < 17'(INERTIA_FALL)) ? 17'd0 :
				{1'b0, inertia_q} - 17'(INERTIA_FALL);
	end

	assign pm  = p_q[38:0];
	assign m_v = vq_q[23] ? 16'(pm >> (23 + REVERSE_SHIFT)) : pm[38:23];
	assign m_w = pm[38:23];

	always_comb begin
		case (cmd.op)
			OP_MUL_R: begin
				mul_a = x_q;
				mul_b = INV_GAIN;
			end
			OP_MUL_V: begin
				mul_a = 28'(r_err_q);
				mul_b = $signed({2'd0, cfg.distance_gain});
			end
			OP_MUL_W: begin
				mul_a = 28'(s_err_q);
				mul_b = $signed({2'd0, cfg.turn_gain});
			end
			OP_MUL_S: begin
				mul_a = $signed({4'd0, av});
				mul_b = $signed({3'd0, span_d});
			end
			OP_MUL_OV: begin
				mul_a = $signed({4'd0, av});
				mul_b = $signed({2'd0, inertia_q});
			end
			OP_MUL_OW: begin
				mul_a = $signed({4'd0, aw});
				mul_b = $signed({2'd0, inertia_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q <= '0;
			inertia_q <= '0;
		end else begin
			if (cmd.op == OP_LOAD)
				hc_q <= hc_n;
			if (cmd.op == OP_FIN)
				inertia_q <= in_n[15:0];
		end
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		case (cmd.op)
			OP_LOAD: begin
				zero_q <= (hand_x == 16'sd0) && (hand_y == 16'sd0);
				if (hand_x < 16'sd0) begin
					x_q <= -hx_s;
					y_q <= -hy_s;
					acc_q <= (hand_y >= 16'sd0) ? DEG180 : -DEG180;
				end else begin
					x_q <= hx_s;
					y_q <= hy_s;
					acc_q <= '0;
				end
			end
			OP_ROT: begin
				if (y_q > 28'sd0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					acc_q <= acc_q + at;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					acc_q <= acc_q - at;
				end
			end
			OP_ERR: begin
				r_err_q <= $signed({2'd0, cfg.target_distance}) -
					$signed({1'b0, zero_q ? 17'd0 : r_val});
				s_err_q <= 17'(cfg.target_angle) - 17'(zero_q ? 16'sd0 : bearing);
			end
			OP_CLP_V: begin
				if (p_q > vlim)
					vq_q <= vlim[23:0];
				else if (p_q < -vlim)
					vq_q <= 24'(-vlim);
				else
					vq_q <= p_q[23:0];
			end
			OP_CLP_W: begin
				if (p_q > wlim)
					wq_q <= wlim[23:0];
				else if (p_q < -wlim)
					wq_q <= 24'(-wlim);
				else
					wq_q <= p_q[23:0];
			end
			OP_DIV_I: begin
				rem_q <= p_q[37:23];
				dv_q <= p_q[22:0];
			end
			OP_DIV: begin
				rem_q <= ge ? 15'(dt - {1'b0, span_e}) : dt[14:0];
				dv_q <= {dv_q[DIV_BITS-2:0], ge};
			end
			OP_FIN: begin
				vq_q <= vq_q[23] ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});
			end
			OP_OUT_V: begin
				v_q <= vq_q[23] ? -$signed(m_v) : $signed(m_v);
			end
			OP_OUT_W: begin
				w_q <= wq_q[23] ? -$signed(m_w) : $signed(m_w);
			end
			OP_PUSH: begin
				forward_speed <= (hc_q == 7'd0) ? 16'sd0 : v_q;
				turn_rate <= (hc_q == 7'd0) ? 16'sd0 : w_q;
				follow_active <= hc_q != 7'd0;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/hfdc_ctrl.sv
// Sequencer: steps the datapath through one request and owns the handshakes.
`include "hand_follow_drive_controller_defines.svh"
module hfdc_ctrl import hfdc_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_ROT   = 5'd1;
	localparam logic [4:0] S_MR    = 5'd2;
	localparam logic [4:0] S_ERR   = 5'd3;
	localparam logic [4:0] S_MV    = 5'd4;
	localparam logic [4:0] S_CV    = 5'd5;
	localparam logic [4:0] S_MW    = 5'd6;
	localparam logic [4:0] S_CW    = 5'd7;
	localparam logic [4:0] S_MS    = 5'd8;
	localparam logic [4:0] S_DI    = 5'd9;
	localparam logic [4:0] S_DV    = 5'd10;
	localparam logic [4:0] S_FIN   = 5'd11;
	localparam logic [4:0] S_MOV   = 5'd12;
	localparam logic [4:0] S_OV    = 5'd13;
	localparam logic [4:0] S_MOW   = 5'd14;
	localparam logic [4:0] S_OW    = 5'd15;
	localparam logic [4:0] S_PUSH  = 5'd16;

	logic [4:0] state_q, state_n;
	logic [4:0] cnt_q;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_n = state_q;
		cmd.op = OP_NOP;
		cmd.idx = cnt_q;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.op = OP_LOAD;
				state_n = S_ROT;
			end
			S_ROT: begin
				cmd.op = OP_ROT;
				if (cnt_q == 5'(CORDIC_STEPS - 1))
					state_n = S_MR;
			end
			S_MR: begin cmd.op = OP_MUL_R; state_n = S_ERR; end
			S_ERR: begin cmd.op = OP_ERR; state_n = S_MV; end
			S_MV: begin cmd.op = OP_MUL_V; state_n = S_CV; end
			S_CV: begin cmd.op = OP_CLP_V; state_n = S_MW; end
			S_MW: begin cmd.op = OP_MUL_W; state_n = S_CW; end
			S_CW: begin cmd.op = OP_CLP_W; state_n = S_MS; end
			S_MS: begin cmd.op = OP_MUL_S; state_n = S_DI; end
			S_DI: begin cmd.op = OP_DIV_I; state_n = S_DV; end
			S_DV: begin
				cmd.op = OP_DIV;
				if (cnt_q == 5'(DIV_BITS - 1))
					state_n = S_FIN;
			end
			S_FIN: begin cmd.op = OP_FIN; state_n = S_MOV; end
			S_MOV: begin cmd.op = OP_MUL_OV; state_n = S_OV; end
			S_OV: begin cmd.op = OP_OUT_V; state_n = S_MOW; end
			S_MOW: begin cmd.op = OP_MUL_OW; state_n = S_OW; end
			S_OW: begin cmd.op = OP_OUT_W; state_n = S_PUSH; end
			S_PUSH: if (slot_free) begin
				cmd.op = OP_PUSH;
				state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_n != state_q)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + 5'd1;
			if (state_q == S_PUSH && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	`HFDC_ASSERT(a_accept_starts, in_valid && in_ready |=> state_q == S_ROT, "accept did not start CORDIC")
	`HFDC_NEVER(a_rot_count, state_q == S_ROT && cnt_q >= 5'(CORDIC_STEPS), "CORDIC overrun")
	`HFDC_NEVER(a_div_count, state_q == S_DV && cnt_q >= 5'(DIV_BITS), "divider overrun")
	`HFDC_ASSERT(a_push_holds, state_q == S_PUSH && out_valid_q && !out_ready |=> state_q == S_PUSH && out_valid_q, "result overwritten")

endmodule

>>> rtl/hand_follow_drive_controller.sv
// Top level of the hand follow drive controller: configuration registers and core.
// Usage:
//   Input channel in_valid/in_ready carries one hand position (hand_x, hand_y,
//   hand_z, signed mm) per request. Output channel out_valid/out_ready returns one
//   wheel command (forward_speed, turn_rate, follow_active) per request.
//   A request goes through CORDIC_STEPS CORDIC iterations, then a shared 28x18
//   multiplier for gains and scaling and a bit-serial 23 step divider for the
//   bearing slowdown. One request is in flight at a time, and the next is
//   taken the cycle after the result is loaded into the output register.
//   A finished result waits in the output register while the next request is
//   taken and worked on; if the receiver still stalls when that one finishes,
//   the core holds it until the register frees.
//   Configuration is written through cfg_write/cfg_index/cfg_data, one register
//   per cycle; the user must write it only while idle, and the block itself does
//   not enforce this. Reset (arst_n low) restores register defaults and clears
//   the height counter and inertia.
module hand_follow_drive_controller import hfdc_pkg::*; #(
	parameter int COUNT_MAX     = 64,
	parameter int COUNT_DROP    = 2,
	parameter int INERTIA_RISE  = 1024,
	parameter int INERTIA_FALL  = 2048,
	parameter int REVERSE_SHIFT = 1,
	parameter int CORDIC_STEPS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] hand_x,
	input  logic signed [15:0] hand_y,
	input  logic signed [15:0] hand_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] forward_speed,
	output logic signed [15:0] turn_rate,
	output logic               follow_active
);

	cfg_t cfg_q;
	cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_distance <= 16'd400;
			cfg_q.target_angle <= 16'sd0;
			cfg_q.distance_gain <= 16'd256;
			cfg_q.turn_gain <= 16'd256;
			cfg_q.max_speed <= 15'd8192;
			cfg_q.max_turn_speed <= 15'd8192;
			cfg_q.height_threshold <= 16'sd0;
			cfg_q.angle_error_span <= 15'd11520;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_TARGET_DISTANCE:  cfg_q.target_distance <= cfg_data;
				REG_TARGET_ANGLE:     cfg_q.target_angle <= $signed(cfg_data);
				REG_DISTANCE_GAIN:    cfg_q.distance_gain <= cfg_data;
				REG_TURN_GAIN:        cfg_q.turn_gain <= cfg_data;
				REG_MAX_SPEED:        cfg_q.max_speed <= cfg_data[14:0];
				REG_MAX_TURN_SPEED:   cfg_q.max_turn_speed <= cfg_data[14:0];
				REG_HEIGHT_THRESHOLD: cfg_q.height_threshold <= $signed(cfg_data);
				REG_ANGLE_SPAN:       cfg_q.angle_error_span <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	hfdc_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd)
	);

	hfdc_datapath #(
		.COUNT_MAX(COUNT_MAX),
		.COUNT_DROP(COUNT_DROP),
		.INERTIA_RISE(INERTIA_RISE),
		.INERTIA_FALL(INERTIA_FALL),
		.REVERSE_SHIFT(REVERSE_SHIFT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg(cfg_q),
		.hand_x(hand_x),
		.hand_y(hand_y),
		.hand_z(hand_z),
		.forward_speed(forward_speed),
		.turn_rate(turn_rate),
		.follow_active(follow_active)
	);

endmodule

>>> tb/tb.sv
// Self-checking bench for the hand follow drive controller: random hand positions, checked commands.
`timescale 1ns / 100ps

module tb import hfdc_pkg::*; ();

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} hand_req_t;

	typedef struct packed {
		logic signed [15:0] fwd;
		logic signed [15:0] turn;
		logic               follow;
	} drive_cmd_t;

	localparam int LIMIT_CYCLES = 400000;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] hand_x, hand_y, hand_z;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] forward_speed, turn_rate;
	logic follow_active;

	hand_follow_drive_controller uut (.*);

	hand_req_t  pending_hands[$];
	drive_cmd_t expected_cmds[$];
	int errors;
	int cycles;
	bit calm;
	bit hold_sender;

	// predictor state
	cfg_t p_cfg;
	int   p_count;
	int   p_inertia;

	function automatic longint unsigned_mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint asr64(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint apply_inertia(longint q, int extra, int iner);
		longint m;
		m = unsigned_mag(q);
		m = (m * iner) >>> (23 + extra);
		return q < 0 ? -m : m;
	endfunction

	function automatic drive_cmd_t predict_command(hand_req_t h);
		longint atan_tbl[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
			58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
		longint cx, cy, acc, dx, dy, rad, brg, rerr, serr, vlim, wlim, vq, wq;
		longint span, e, ni, v, w;
		drive_cmd_t c;
		cx = longint'(h.x) * 256;
		cy = longint'(h.y) * 256;
		acc = 0;
		rad = 0;
		brg = 0;
		if (h.x != 0 || h.y != 0) begin
			if (cx < 0) begin
				acc = (h.y >= 0) ? 64'sd11796480 : -64'sd11796480;
				cx = -cx;
				cy = -cy;
			end
			for (int i = 0; i < 16; i++) begin
				dx = asr64(cy, i);
				dy = asr64(cx, i);
				if (cy > 0) begin
					cx += dx; cy -= dy; acc += atan_tbl[i];
				end else begin
					cx -= dx; cy += dy; acc -= atan_tbl[i];
				end
			end
			rad = (cx * 39797 + (64'sd1 <<< 23)) >>> 24;
			brg = clamp(asr64(acc + 256, 9), -23040, 23040);
		end
		rerr = longint'(p_cfg.target_distance) - rad;
		serr = longint'(p_cfg.target_angle) - brg;
		vlim = longint'(p_cfg.max_speed) <<< 8;
		wlim = longint'(p_cfg.max_turn_speed) <<< 8;
		vq = clamp(rerr * longint'(p_cfg.distance_gain), -vlim, vlim);
		wq = clamp(serr * longint'(p_cfg.turn_gain), -wlim, wlim);
		span = p_cfg.angle_error_span != 0 ? longint'(p_cfg.angle_error_span) : 1;
		e = unsigned_mag(serr);
		if (e > span) e = span;
		vq = vq * (span - e) / span;
		if (longint'(h.z) > longint'(p_cfg.height_threshold)) p_count += 1;
		else p_count -= 2;
		p_count = int'(clamp(p_count, 0, 64));
		ni = p_inertia;
		if (unsigned_mag(vq) > (longint'(p_cfg.max_speed) <<< 4) ||
		    unsigned_mag(wq) > (longint'(p_cfg.max_turn_speed) <<< 4))
			ni += 1024;
		else
			ni -= 2048;
		p_inertia = int'(clamp(ni, 0, 32768));
		if (p_count < 1) begin
			v = 0; w = 0; p_inertia = 0;
		end else begin
			v = apply_inertia(vq, vq < 0 ? 1 : 0, p_inertia);
			w = apply_inertia(wq, 0, p_inertia);
		end
		c.fwd = v[15:0];
		c.turn = w[15:0];
		c.follow = p_count >= 1;
		return c;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_cmds.push_back(predict_command({hand_x, hand_y, hand_z}));
				pending_hands.pop_front();
			end
			if (!(in_valid && !in_ready)) begin
				if (pending_hands.size() > 0 && !hold_sender
				    && (calm || $urandom_range(99) >= 19)
				    && !(in_valid && in_ready && pending_hands.size() < 2)) begin
					// next item is head after pop above
					in_valid <= 1;
					hand_x <= pending_hands[0].x;
					hand_y <= pending_hands[0].y;
					hand_z <= pending_hands[0].z;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_cmds.size() == 0) begin
					$display("%0t: unexpected command fwd=%0d turn=%0d", $time,
						forward_speed, turn_rate);
					errors++;
				end else begin
					drive_cmd_t x;
					x = expected_cmds.pop_front();
					if (x.fwd !== forward_speed) begin
						$display("%0t: forward_speed exp %0d got %0d", $time, x.fwd,
							forward_speed);
						errors++;
					end
					if (x.turn !== turn_rate) begin
						$display("%0t: turn_rate exp %0d got %0d", $time, x.turn, turn_rate);
						errors++;
					end
					if (x.follow !== follow_active) begin
						$display("%0t: follow_active exp %0b got %0b", $time, x.follow,
							follow_active);
						errors++;
					end
				end
			end
			out_ready <= calm || $urandom_range(99) >= 19;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_TARGET_DISTANCE:  p_cfg.target_distance = val;
			REG_TARGET_ANGLE:     p_cfg.target_angle = val;
			REG_DISTANCE_GAIN:    p_cfg.distance_gain = val;
			REG_TURN_GAIN:        p_cfg.turn_gain = val;
			REG_MAX_SPEED:        p_cfg.max_speed = val[14:0];
			REG_MAX_TURN_SPEED:   p_cfg.max_turn_speed = val[14:0];
			REG_HEIGHT_THRESHOLD: p_cfg.height_threshold = val;
			default:              p_cfg.angle_error_span = val[14:0];
		endcase
		@(posedge clk);
		cfg_write <= 0;
	endtask

	task automatic drain();
		while (pending_hands.size() > 0 || in_valid || expected_cmds.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(1200) - 600);
			2: return 16'($urandom_range(6000) - 3000);
			default: return 16'($urandom_range(200) - 100);
		endcase
	endfunction

	task automatic queue_random(int n, int bool_high_z);
		hand_req_t h;
		for (int i = 0; i < n; i++) begin
			h.x = rand_coord();
			h.y = rand_coord();
			// mostly above the threshold when bool_high_z is set, so following engages
			h.z = ($urandom_range(9) < 8 - (bool_high_z ? 0 : 4)) ?
				16'(500 + $urandom_range(900)) :
				($urandom_range(1) ? -16'sd200 : 16'($urandom));
			pending_hands.push_back(h);
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		calm = 0;
		hold_sender = 0;
		arst_n = 0;
		cfg_write = 0;
		cfg_index = '0;
		cfg_data = '0;
		hand_x = 0; hand_y = 0; hand_z = 0;
		p_cfg = '{16'd400, 16'sd0, 16'd256, 16'd256, 15'd8192, 15'd8192, 16'sd0, 15'd11520};
		p_count = 0;
		p_inertia = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: origin, axes, extremes, heights around threshold
		pending_hands.push_back('{16'sd0, 16'sd0, 16'sd10});
		pending_hands.push_back('{16'sd32767, 16'sd0, 16'sd10});
		pending_hands.push_back('{-16'sd32768, 16'sd0, 16'sd10});
		pending_hands.push_back('{-16'sd32768, -16'sd1, 16'sd10});
		pending_hands.push_back('{16'sd0, 16'sd32767, 16'sd10});
		pending_hands.push_back('{16'sd0, -16'sd32768, 16'sd10});
		pending_hands.push_back('{-16'sd32768, -16'sd32768, 16'sd32767});
		pending_hands.push_back('{16'sd32767, 16'sd32767, 16'sd32767});
		pending_hands.push_back('{-16'sd1, 16'sd0, 16'sd0});
		pending_hands.push_back('{-16'sd1, -16'sd1, -16'sd32768});
		pending_hands.push_back('{16'sd100, 16'sd50, 16'sd1});
		pending_hands.push_back('{16'sd400, 16'sd0, 16'sd1});
		pending_hands.push_back('{16'sd10, -16'sd300, -16'sd1});
		pending_hands.push_back('{-16'sd5000, 16'sd5000, 16'sd200});
		pending_hands.push_back('{16'sd3, 16'sd4, 16'sd200});
		drain();

		queue_random(150, 1);
		// mid-stream, sender holds off until all commands are back
		while (pending_hands.size() > 75)
			@(posedge clk);
		hold_sender = 1;
		@(posedge clk);
		while (in_valid || expected_cmds.size() > 0)
			@(posedge clk);
		hold_sender = 0;
		drain();
		queue_random(60, 0);
		drain();

		// extremes of the registers
		write_reg(REG_TARGET_DISTANCE, 16'd46341);
		write_reg(REG_TARGET_ANGLE, -16'sd23040);
		write_reg(REG_DISTANCE_GAIN, 16'hFFFF);
		write_reg(REG_TURN_GAIN, 16'hFFFF);
		write_reg(REG_MAX_SPEED, 16'h7FFF);
		write_reg(REG_MAX_TURN_SPEED, 16'h7FFF);
		write_reg(REG_HEIGHT_THRESHOLD, -16'sd32768);
		write_reg(REG_ANGLE_SPAN, 16'd1);
		queue_random(120, 1);
		drain();

		write_reg(REG_TARGET_DISTANCE, 16'd0);
		write_reg(REG_TARGET_ANGLE, 16'sd23040);
		write_reg(REG_DISTANCE_GAIN, 16'd0);
		write_reg(REG_TURN_GAIN, 16'd1);
		write_reg(REG_MAX_SPEED, 16'd0);
		write_reg(REG_MAX_TURN_SPEED, 16'd100);
		write_reg(REG_HEIGHT_THRESHOLD, 16'sd32767);
		write_reg(REG_ANGLE_SPAN, 16'd0);
		queue_random(40, 1);
		drain();

		// all bits of several registers, then random mid values; one phase runs with a calm handshake
		write_reg(REG_TARGET_DISTANCE, 16'hFFFF);
		write_reg(REG_TARGET_ANGLE, 16'h7FFF);
		write_reg(REG_MAX_SPEED, 16'hFFFF);
		write_reg(REG_ANGLE_SPAN, 16'hFFFF);
		write_reg(REG_HEIGHT_THRESHOLD, 16'h8001);
		queue_random(60, 1);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_TARGET_DISTANCE, 16'($urandom_range(2000)));
			write_reg(REG_TARGET_ANGLE, 16'($urandom_range(46080) - 23040));
			write_reg(REG_DISTANCE_GAIN, 16'($urandom_range(2048)));
			write_reg(REG_TURN_GAIN, 16'($urandom_range(2048)));
			write_reg(REG_MAX_SPEED, 16'($urandom_range(32767)));
			write_reg(REG_MAX_TURN_SPEED, 16'($urandom_range(32767)));
			write_reg(REG_HEIGHT_THRESHOLD, 16'($urandom_range(400)));
			write_reg(REG_ANGLE_SPAN, 16'($urandom_range(23040, 1)));
			calm = (ph == 1);
			queue_random(105, int'(ph != 3));
			drain();
		end
		calm = 0;

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
